// ----- rtl/core/ccf_pkg.sv -----
// ccf_pkg: shared types, codes and CRC-16/ARC helpers for the command frame codec.
// Used by ccf_front, ccf_fifo, ccf_back and the top level; depends on nothing.
`default_nettype none

package ccf_pkg;

   localparam logic [7:0]  START_MARK = 8'h23;  // '#'
   localparam logic [7:0]  END_MARK   = 8'h24;  // '$'
   localparam logic [7:0]  ESC_BYTE   = 8'h31;  // '1'
   localparam logic [7:0]  NUL_BYTE   = 8'h00;
   localparam logic [15:0] CRC_POLY   = 16'hA001;

   localparam logic MODE_TX = 1'b0;

   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

   typedef enum logic [1:0] {
      KIND_TX_LINE    = 2'd0,
      KIND_RX_DATA    = 2'd1,
      KIND_RX_VERDICT = 2'd2
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_MISMATCH = 2'd1,
      ST_TRUNC    = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      RX_HUNT = 3'd0,
      RX_DATA = 3'd1,
      RX_CLO  = 3'd2,
      RX_CHI  = 3'd3,
      RX_END  = 3'd4
   } rx_phase_type;

   // Output slot of a transmit burst
   typedef enum logic [2:0] {
      SL_START = 3'd0,
      SL_BYTE  = 3'd1,
      SL_NUL   = 3'd2,
      SL_LO    = 3'd3,
      SL_HI    = 3'd4,
      SL_END   = 3'd5
   } slot_type;

   // One queued work descriptor: what the back end has to emit for one transaction
   typedef struct packed {
      logic       is_rx;
      logic       open;      // tx: emit start marker first
      logic       close;     // tx: emit trailer after the byte
      logic       verdict;   // rx: verdict instead of payload byte
      status_type status;
      logic [7:0] data_byte;
      logic [7:0] crc_lo;    // already escaped
      logic [7:0] crc_hi;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
      logic [15:0] c;
      c = crc ^ {8'h00, b};
      for (int i = 0; i < 8; i++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

   function automatic logic [7:0] esc(input logic [7:0] b);
      return (b == END_MARK) ? ESC_BYTE : b;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/core/ccf_req_if.sv -----
// ccf_req_if: input channel of the codec (valid/ready plus request fields).
// Depends on nothing.
`default_nettype none

interface ccf_req_if;
   logic       valid;
   logic       ready;
   logic       mode;
   logic [7:0] data_byte;
   logic       last_byte;

   modport source (output valid, mode, data_byte, last_byte, input ready);
   modport sink   (input valid, mode, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/ccf_rsp_if.sv -----
// ccf_rsp_if: result channel of the codec (valid/ready plus result fields).
// Depends on nothing.
`default_nettype none

interface ccf_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] kind;
   logic [7:0] out_byte;
   logic       run_last;
   logic [1:0] frame_status;

   modport source (output valid, kind, out_byte, run_last, frame_status, input ready);
   modport sink   (input valid, kind, out_byte, run_last, frame_status, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/crc16_command_frame_codec.sv -----
// CRC-16/ARC command frame codec, top level: front end, descriptor queue, back end.
// With the queue empty, the first result of a transaction passes the queue write and
// then the back end output register before it is valid.
// Throughput: one transaction per cycle while each gives at most one result and
// rsp_ch is ready; a closing tx byte gives up to six results, one per cycle while
// rsp_ch is ready, and a 4-entry descriptor queue lets the front keep accepting.
`default_nettype none

module crc16_command_frame_codec
   import ccf_pkg::*;
(
   input  wire logic clock,
   input  wire logic reset,
   ccf_req_if.sink   req_ch,
   ccf_rsp_if.source rsp_ch
);

   // Reset (synchronous): no tx frame open, rx hunting for start, CRCs and queue cleared.

   fifo_stat_type fifo_stat;
   desc_type      push_desc;
   desc_type      head;
   logic          push;
   logic          pop;

   ccf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .fifo_stat (fifo_stat),
      .push      (push),
      .push_desc (push_desc)
   );

   ccf_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .head      (head),
      .stat      (fifo_stat)
   );

   ccf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .fifo_stat (fifo_stat),
      .pop       (pop),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ----- rtl/core/ccf_front.sv -----
// ccf_front: accepts transactions, runs the tx/rx framing state and CRCs,
// and pushes one descriptor per transaction that yields results. Uses ccf_pkg.
`default_nettype none

module ccf_front
   import ccf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   ccf_req_if.sink       req_ch,
   input  wire fifo_stat_type fifo_stat,
   output logic          push,
   output desc_type      push_desc
);

   logic         tx_in_frame_ff, tx_in_frame_in;
   logic [15:0]  tx_check_ff, tx_check_in;
   rx_phase_type rx_phase_ff, rx_phase_in;
   logic [15:0]  rx_check_ff, rx_check_in;
   logic [15:0]  rx_got_ff, rx_got_in;

   logic         accept;
   logic         is_rx;
   logic         is_end;
   logic [15:0]  tx_crc;
   logic [15:0]  rx_crc;
   logic [15:0]  rx_want;

   assign req_ch.ready = !fifo_stat.full;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_rx        = (req_ch.mode != MODE_TX);
   assign is_end       = (req_ch.data_byte == END_MARK);

   assign tx_crc  = crc_byte(tx_in_frame_ff ? tx_check_ff : 16'h0000, req_ch.data_byte);
   assign rx_crc  = crc_byte(rx_check_ff, req_ch.data_byte);
   assign rx_want = {esc(rx_check_ff[15:8]), esc(rx_check_ff[7:0])};

   // receive phase next state
   always_comb begin
      rx_phase_in = rx_phase_ff;
      if (accept && is_rx) begin
         case (rx_phase_ff)
            RX_DATA: begin
               if (req_ch.data_byte == NUL_BYTE) begin
                  rx_phase_in = RX_CLO;
               end else if (is_end) begin
                  rx_phase_in = RX_HUNT;
               end
            end
            RX_CLO: rx_phase_in = is_end ? RX_HUNT : RX_CHI;
            RX_CHI: rx_phase_in = is_end ? RX_HUNT : RX_END;
            RX_END: begin
               if (is_end) begin
                  rx_phase_in = RX_HUNT;
               end
            end
            default: rx_phase_in = (req_ch.data_byte == START_MARK) ? RX_DATA : RX_HUNT;
         endcase
      end
   end

   // datapath updates and descriptor
   always_comb begin
      push           = 1'b0;
      push_desc      = '0;
      tx_in_frame_in = tx_in_frame_ff;
      tx_check_in    = tx_check_ff;
      rx_check_in    = rx_check_ff;
      rx_got_in      = rx_got_ff;
      push_desc.data_byte = req_ch.data_byte;
      push_desc.crc_lo    = esc(tx_crc[7:0]);
      push_desc.crc_hi    = esc(tx_crc[15:8]);
      push_desc.is_rx     = is_rx;
      if (accept && !is_rx) begin
         push            = 1'b1;
         push_desc.open  = !tx_in_frame_ff;
         push_desc.close = req_ch.last_byte;
         if (req_ch.last_byte) begin
            tx_in_frame_in = 1'b0;
            tx_check_in    = 16'h0000;
         end else begin
            tx_in_frame_in = 1'b1;
            tx_check_in    = tx_crc;
         end
      end else if (accept) begin
         case (rx_phase_ff)
            RX_DATA: begin
               if (is_end) begin
                  push              = 1'b1;
                  push_desc.verdict = 1'b1;
                  push_desc.status  = ST_TRUNC;
               end else if (req_ch.data_byte != NUL_BYTE) begin
                  push        = 1'b1;
                  rx_check_in = rx_crc;
               end
            end
            RX_CLO, RX_CHI: begin
               if (is_end) begin
                  push              = 1'b1;
                  push_desc.verdict = 1'b1;
                  push_desc.status  = ST_TRUNC;
               end else if (rx_phase_ff == RX_CLO) begin
                  rx_got_in[7:0] = req_ch.data_byte;
               end else begin
                  rx_got_in[15:8] = req_ch.data_byte;
               end
            end
            RX_END: begin
               if (is_end) begin
                  push              = 1'b1;
                  push_desc.verdict = 1'b1;
                  push_desc.status  = (rx_want == rx_got_ff) ? ST_OK : ST_MISMATCH;
               end
            end
            default: begin
               if (req_ch.data_byte == START_MARK) begin
                  rx_check_in = 16'h0000;
                  rx_got_in   = 16'h0000;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tx_in_frame_ff <= 1'b0;
         tx_check_ff    <= 16'h0000;
         rx_phase_ff    <= RX_HUNT;
         rx_check_ff    <= 16'h0000;
         rx_got_ff      <= 16'h0000;
      end else begin
         tx_in_frame_ff <= tx_in_frame_in;
         tx_check_ff    <= tx_check_in;
         rx_phase_ff    <= rx_phase_in;
         rx_check_ff    <= rx_check_in;
         rx_got_ff      <= rx_got_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ccf_fifo.sv -----
// ccf_fifo: small descriptor queue between front and back end.
// Uses ccf_pkg (desc_type, FIFO_DEPTH).
`default_nettype none

module ccf_fifo
   import ccf_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire logic      push,
   input  wire desc_type  push_desc,
   input  wire logic      pop,
   output desc_type       head,
   output fifo_stat_type  stat
);

   localparam logic [FIFO_AW:0] DEPTH_CNT = (FIFO_AW + 1)'(FIFO_DEPTH);

   desc_type             mem_ff [FIFO_DEPTH];
   logic [FIFO_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FIFO_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FIFO_AW:0]     count_ff, count_in;
   logic                 do_push;
   logic                 do_pop;

   assign stat.full  = (count_ff == DEPTH_CNT);
   assign stat.empty = (count_ff == '0);
   assign head       = mem_ff[rd_ptr_ff];

   assign do_push = push && !stat.full;
   assign do_pop  = pop && !stat.empty;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ----- rtl/core/ccf_back.sv -----
// ccf_back: walks each queued descriptor and emits its results one per cycle
// into a registered output stage while rsp_ch is not stalled. Uses ccf_pkg.
`default_nettype none

module ccf_back
   import ccf_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire desc_type head,
   input  wire fifo_stat_type fifo_stat,
   output logic          pop,
   ccf_rsp_if.source     rsp_ch
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff, kind_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic [1:0] status_ff, status_in;
   logic       first_ff, first_in;
   slot_type   step_ff, step_in;

   slot_type   slot;
   slot_type   start_slot;
   slot_type   end_slot;
   logic       advance;
   logic       at_end;

   assign start_slot = (head.is_rx || head.open) ? SL_START : SL_BYTE;
   assign end_slot   = head.is_rx ? SL_START : (head.close ? SL_END : SL_BYTE);
   assign slot       = first_ff ? start_slot : step_ff;
   assign at_end     = (slot == end_slot);
   assign advance    = !fifo_stat.empty && (!valid_ff || rsp_ch.ready);
   assign pop        = advance && at_end;

   always_comb begin
      valid_in  = valid_ff;
      kind_in   = kind_ff;
      byte_in   = byte_ff;
      last_in   = last_ff;
      status_in = status_ff;
      first_in  = first_ff;
      step_in   = step_ff;
      if (advance) begin
         valid_in  = 1'b1;
         last_in   = at_end;
         status_in = ST_OK;
         if (head.is_rx) begin
            if (head.verdict) begin
               kind_in   = KIND_RX_VERDICT;
               byte_in   = 8'h00;
               status_in = head.status;
            end else begin
               kind_in = KIND_RX_DATA;
               byte_in = head.data_byte;
            end
         end else begin
            kind_in = KIND_TX_LINE;
            case (slot)
               SL_START: byte_in = START_MARK;
               SL_BYTE:  byte_in = head.data_byte;
               SL_NUL:   byte_in = NUL_BYTE;
               SL_LO:    byte_in = head.crc_lo;
               SL_HI:    byte_in = head.crc_hi;
               default:  byte_in = END_MARK;
            endcase
         end
         if (at_end) begin
            first_in = 1'b1;
         end else begin
            first_in = 1'b0;
            step_in  = slot_type'(slot + 3'd1);
         end
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         first_ff <= 1'b1;
         step_ff  <= SL_START;
      end else begin
         valid_ff <= valid_in;
         first_ff <= first_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff   <= kind_in;
      byte_ff   <= byte_in;
      last_ff   <= last_in;
      status_ff <= status_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = kind_ff;
   assign rsp_ch.out_byte     = byte_ff;
   assign rsp_ch.run_last     = last_ff;
   assign rsp_ch.frame_status = status_ff;

endmodule

`default_nettype wire
